@@ rtl/core/ogru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid ray update package
// Shared sizes, command codes, cell constants and helper functions.
// ----------------------------------------------------------------------------
package ogru_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 128;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = 11;
    localparam int CELL_W   = 20;
    localparam int DATA_W   = 16;

    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);
    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic signed [DATA_W-1:0] FREE_INC  = 16'sd90;
    localparam logic signed [DATA_W-1:0] OCC_VALUE = -16'sd256;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_COLS  = 3'd0,
        REG_ROWS  = 3'd1,
        REG_HALFX = 3'd2,
        REG_HALFY = 3'd3,
        REG_SCALE = 3'd4
    } reg_index_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] d
    );
        logic signed [DATA_W:0] s;
        s = $signed({a[DATA_W-1], a}) + $signed({d[DATA_W-1], d});
        if (s > 17'sd32767)
            return 16'sh7FFF;
        else if (s < -17'sd32768)
            return 16'sh8000;
        else
            return s[DATA_W-1:0];
    endfunction

    function automatic logic inside_grid(
        input logic signed [CELL_W-1:0] x,
        input logic signed [CELL_W-1:0] y,
        input logic [CNT_W-1:0]         uc,
        input logic [CNT_W-1:0]         ur
    );
        return (x >= 0) && (x < $signed({{(CELL_W-CNT_W){1'b0}}, uc}))
            && (y >= 0) && (y < $signed({{(CELL_W-CNT_W){1'b0}}, ur}));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic signed [CELL_W-1:0] x,
        input logic signed [CELL_W-1:0] y
    );
        return ADDR_W'(32'(x[COL_W-1:0]) * 32'(MAX_ROWS) + 32'(y[ROW_W-1:0]));
    endfunction

endpackage

@@ rtl/core/occupancy_grid_ray_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid ray update
// Log-odds grid with ray trace, hit stamp, cell read, cell add and clear.
// ----------------------------------------------------------------------------
// Every command gives one result word on cell_value and in_bounds, marked by a
// one-cycle done pulse that the receiver must take. A scan point traces
// span+1 cells, span being max(|dx|,|dy|) in cells, and stamps the 3x3 block
// round the hit cell when that lies in the grid. The cell store has one read
// and one write port and each traced cell is a read followed by a write. A
// read or add is a read state then a write state (out of bounds it answers
// from idle); a clear writes all 16384 entries, one store entry a cycle.
// After reset the same clearing pass runs with busy high and gives no
// result; configuration writes are taken at any time.
module occupancy_grid_ray_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic signed [15:0] hit_x,
    input  logic signed [15:0] hit_y,
    input  logic signed [15:0] robot_x,
    input  logic signed [15:0] robot_y,
    input  logic [7:0]  cell_col,
    input  logic [7:0]  cell_row,
    input  logic signed [15:0] delta_value,
    output logic        done,
    output logic signed [15:0] cell_value,
    output logic        in_bounds,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = ogru_pkg::CELL_W;
    localparam logic signed [CW-1:0] ONE = CW'(1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLEAR = 9'b000000010,
        ST_MAP   = 9'b000000100,
        ST_SETUP = 9'b000001000,
        ST_TR_RD = 9'b000010000,
        ST_TR_WR = 9'b000100000,
        ST_STAMP = 9'b001000000,
        ST_RW_RD = 9'b010000000,
        ST_RW_WR = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [7:0]  grid_cols_reg, grid_rows_reg;
    logic [14:0] half_x_reg, half_y_reg;
    logic [15:0] scale_reg;

    logic [1:0]  cmd_reg;
    logic signed [15:0] hit_x_reg, hit_y_reg, robot_x_reg, robot_y_reg, delta_reg;
    logic [7:0]  col_reg, row_reg;
    logic [2:0]  map_cnt_reg;
    logic signed [CW-1:0] hx_reg, hy_reg, rx_reg, ry_reg;
    logic signed [CW-1:0] ddx_reg, ddy_reg, span_reg, step_reg;
    logic signed [CW-1:0] qx_reg, qy_reg;
    logic signed [CW:0]   remx_reg, remy_reg;
    logic [ogru_pkg::ADDR_W-1:0] tr_addr_reg, clr_cnt_reg;
    logic        tr_ok_reg, hit_in_reg, clr_report_reg;
    logic [1:0]  sa_reg, sb_reg;
    logic        done_reg, in_bounds_reg;
    logic        done_next;
    logic signed [15:0] cell_value_reg;

    logic [ogru_pkg::CNT_W-1:0] uc, ur, gc, gr;
    logic signed [15:0] map_coord;
    logic [14:0] map_half;
    logic signed [CW-1:0] map_cell;
    logic signed [CW-1:0] sdx, sdy, sax, say;
    logic signed [CW-1:0] tx, ty, sx, sy, in_col, in_row, col_c, row_c;
    logic signed [CW:0]   rnx, rny, remx_new, remy_new;
    logic signed [CW-1:0] qx_new, qy_new;
    logic        st_in, rw_ok;
    logic        mem_we, mem_re;
    logic [ogru_pkg::ADDR_W-1:0] mem_wa, mem_ra;
    logic [15:0] mem_wd, mem_rd;
    logic signed [15:0] rw_val;

    assign gc = {3'b000, grid_cols_reg};
    assign gr = {3'b000, grid_rows_reg};
    assign uc = (gc > ogru_pkg::MAX_COLS_C) ? ogru_pkg::MAX_COLS_C : gc;
    assign ur = (gr > ogru_pkg::MAX_ROWS_C) ? ogru_pkg::MAX_ROWS_C : gr;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_value = cell_value_reg;
    assign in_bounds  = in_bounds_reg;

    always_comb
    begin
        case (map_cnt_reg)
            3'd0:    map_coord = hit_x_reg;
            3'd1:    map_coord = hit_y_reg;
            3'd2:    map_coord = robot_x_reg;
            default: map_coord = robot_y_reg;
        endcase
        map_half = map_cnt_reg[0] ? half_y_reg : half_x_reg;
    end

    ogru_cell_map u_map (
        .clk      (clk),
        .coord    (map_coord),
        .half     (map_half),
        .scale    (scale_reg),
        .cell_idx (map_cell)
    );

    assign sdx = hx_reg - rx_reg;
    assign sdy = hy_reg - ry_reg;
    assign sax = sdx[CW-1] ? -sdx : sdx;
    assign say = sdy[CW-1] ? -sdy : sdy;

    assign tx = (qx_reg[CW-1] && remx_reg != 0) ? qx_reg + ONE : qx_reg;
    assign ty = (qy_reg[CW-1] && remy_reg != 0) ? qy_reg + ONE : qy_reg;

    always_comb
    begin
        rnx = remx_reg + $signed({ddx_reg[CW-1], ddx_reg});
        rny = remy_reg + $signed({ddy_reg[CW-1], ddy_reg});
        remx_new = rnx;
        qx_new   = qx_reg;
        remy_new = rny;
        qy_new   = qy_reg;
        if (rnx >= $signed({1'b0, span_reg}))
        begin
            remx_new = rnx - $signed({1'b0, span_reg});
            qx_new   = qx_reg + ONE;
        end
        else if (rnx < 0)
        begin
            remx_new = rnx + $signed({1'b0, span_reg});
            qx_new   = qx_reg - ONE;
        end
        if (rny >= $signed({1'b0, span_reg}))
        begin
            remy_new = rny - $signed({1'b0, span_reg});
            qy_new   = qy_reg + ONE;
        end
        else if (rny < 0)
        begin
            remy_new = rny + $signed({1'b0, span_reg});
            qy_new   = qy_reg - ONE;
        end
    end

    assign sx    = hx_reg + $signed({{(CW-2){1'b0}}, sa_reg}) - ONE;
    assign sy    = hy_reg + $signed({{(CW-2){1'b0}}, sb_reg}) - ONE;
    assign st_in = ogru_pkg::inside_grid(sx, sy, uc, ur);

    assign in_col = $signed({{(CW-8){1'b0}}, cell_col});
    assign in_row = $signed({{(CW-8){1'b0}}, cell_row});
    assign col_c  = $signed({{(CW-8){1'b0}}, col_reg});
    assign row_c  = $signed({{(CW-8){1'b0}}, row_reg});
    assign rw_ok  = ogru_pkg::inside_grid(in_col, in_row, uc, ur);

    assign rw_val = (cmd_reg == ogru_pkg::CMD_ADD)
                  ? ogru_pkg::sat_add(mem_rd, delta_reg) : mem_rd;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
            end
            ST_TR_RD:
            begin
                mem_re = ogru_pkg::inside_grid(tx, ty, uc, ur);
                mem_ra = ogru_pkg::cell_addr(tx, ty);
            end
            ST_TR_WR:
            begin
                mem_we = tr_ok_reg;
                mem_wa = tr_addr_reg;
                mem_wd = ogru_pkg::sat_add(mem_rd, ogru_pkg::FREE_INC);
            end
            ST_STAMP:
            begin
                mem_we = st_in;
                mem_wa = ogru_pkg::cell_addr(sx, sy);
                mem_wd = ogru_pkg::OCC_VALUE;
            end
            ST_RW_RD:
            begin
                mem_re = 1'b1;
                mem_ra = ogru_pkg::cell_addr(col_c, row_c);
            end
            ST_RW_WR:
            begin
                mem_we = (cmd_reg == ogru_pkg::CMD_ADD);
                mem_wa = ogru_pkg::cell_addr(col_c, row_c);
                mem_wd = rw_val;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                done_next = start && !rw_ok
                         && (cmd == ogru_pkg::CMD_READ || cmd == ogru_pkg::CMD_ADD);
            end
            ST_CLEAR:
            begin
                done_next = clr_report_reg && (clr_cnt_reg == ogru_pkg::LAST_ADDR);
            end
            ST_TR_WR:
            begin
                done_next = (step_reg == span_reg) && !hit_in_reg;
            end
            ST_STAMP:
            begin
                done_next = (sa_reg == 2'd2) && (sb_reg == 2'd2);
            end
            ST_RW_WR:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    ogru_ram #(
        .ADDR_W (ogru_pkg::ADDR_W),
        .DATA_W (ogru_pkg::DATA_W)
    ) u_ram (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .re  (mem_re),
        .ra  (mem_ra),
        .rd  (mem_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= 8'd128;
            grid_rows_reg <= 8'd128;
            half_x_reg    <= 15'd1638;
            half_y_reg    <= 15'd1638;
            scale_reg     <= 16'd2560;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ogru_pkg::REG_COLS:  grid_cols_reg <= cfg_data[7:0];
                ogru_pkg::REG_ROWS:  grid_rows_reg <= cfg_data[7:0];
                ogru_pkg::REG_HALFX: half_x_reg    <= cfg_data[14:0];
                ogru_pkg::REG_HALFY: half_y_reg    <= cfg_data[14:0];
                ogru_pkg::REG_SCALE: scale_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            map_cnt_reg    <= '0;
            sa_reg         <= '0;
            sb_reg         <= '0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg     <= cmd;
                        hit_x_reg   <= hit_x;
                        hit_y_reg   <= hit_y;
                        robot_x_reg <= robot_x;
                        robot_y_reg <= robot_y;
                        col_reg     <= cell_col;
                        row_reg     <= cell_row;
                        delta_reg   <= delta_value;
                        unique case (cmd)
                            ogru_pkg::CMD_SCAN:
                            begin
                                map_cnt_reg <= '0;
                                state_reg   <= ST_MAP;
                            end
                            ogru_pkg::CMD_READ, ogru_pkg::CMD_ADD:
                            begin
                                if (rw_ok)
                                begin
                                    state_reg <= ST_RW_RD;
                                end
                                else
                                begin
                                    cell_value_reg <= '0;
                                    in_bounds_reg  <= 1'b0;
                                end
                            end
                            default:
                            begin
                                clr_cnt_reg    <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= ST_CLEAR;
                            end
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ogru_pkg::LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                        if (clr_report_reg)
                        begin
                            cell_value_reg <= '0;
                            in_bounds_reg  <= 1'b0;
                        end
                    end
                end
                ST_MAP:
                begin
                    map_cnt_reg <= map_cnt_reg + 1'b1;
                    case (map_cnt_reg)
                        3'd2: hx_reg <= map_cell;
                        3'd3: hy_reg <= map_cell;
                        3'd4: rx_reg <= map_cell;
                        3'd5:
                        begin
                            ry_reg    <= map_cell;
                            state_reg <= ST_SETUP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_SETUP:
                begin
                    ddx_reg    <= sdx;
                    ddy_reg    <= sdy;
                    span_reg   <= (sax > say) ? sax : say;
                    qx_reg     <= rx_reg;
                    qy_reg     <= ry_reg;
                    remx_reg   <= '0;
                    remy_reg   <= '0;
                    step_reg   <= '0;
                    hit_in_reg <= ogru_pkg::inside_grid(hx_reg, hy_reg, uc, ur);
                    state_reg  <= ST_TR_RD;
                end
                ST_TR_RD:
                begin
                    tr_addr_reg <= ogru_pkg::cell_addr(tx, ty);
                    tr_ok_reg   <= ogru_pkg::inside_grid(tx, ty, uc, ur);
                    state_reg   <= ST_TR_WR;
                end
                ST_TR_WR:
                begin
                    if (step_reg == span_reg)
                    begin
                        if (hit_in_reg)
                        begin
                            sa_reg    <= '0;
                            sb_reg    <= '0;
                            state_reg <= ST_STAMP;
                        end
                        else
                        begin
                            cell_value_reg <= '0;
                            in_bounds_reg  <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_reg  <= step_reg + ONE;
                        qx_reg    <= qx_new;
                        qy_reg    <= qy_new;
                        remx_reg  <= remx_new;
                        remy_reg  <= remy_new;
                        state_reg <= ST_TR_RD;
                    end
                end
                ST_STAMP:
                begin
                    if (sb_reg == 2'd2)
                    begin
                        sb_reg <= '0;
                        sa_reg <= sa_reg + 1'b1;
                        if (sa_reg == 2'd2)
                        begin
                            cell_value_reg <= '0;
                            in_bounds_reg  <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        sb_reg <= sb_reg + 1'b1;
                    end
                end
                ST_RW_RD:
                begin
                    state_reg <= ST_RW_WR;
                end
                ST_RW_WR:
                begin
                    cell_value_reg <= rw_val;
                    in_bounds_reg  <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/ogru_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell store RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ogru_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wa,
    input  logic [DATA_W-1:0] wd,
    input  logic              re,
    input  logic [ADDR_W-1:0] ra,
    output logic [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

@@ rtl/core/ogru_cell_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate to cell mapper
// Two-stage pipeline: scale the shifted coordinate, then truncate toward zero.
// ----------------------------------------------------------------------------
module ogru_cell_map (
    input  logic                                 clk,
    input  logic signed [15:0]                   coord,
    input  logic [14:0]                          half,
    input  logic [15:0]                          scale,
    output logic signed [ogru_pkg::CELL_W-1:0]   cell_idx
);

    logic signed [16:0] shifted;
    logic signed [33:0] prod_reg;
    logic [33:0]        mag;
    logic [17:0]        quot;
    logic signed [ogru_pkg::CELL_W-1:0] cell_reg;

    assign shifted  = $signed({coord[15], coord}) + $signed({2'b00, half});
    assign mag      = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign quot     = mag[33:16];
    assign cell_idx = cell_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= shifted * $signed({1'b0, scale});
        if (prod_reg[33])
            cell_reg <= -$signed({2'b00, quot});
        else
            cell_reg <= $signed({2'b00, quot});
    end

endmodule
